/* hw/rtl/dpa_pkg.sv */
// Package with the item types and constants of the double precision adder.
package dpa_pkg;

	localparam int unsigned MaxGap = 54;
	localparam logic [10:0] ExpMax = 11'h7FF;
	localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NegInf = 64'hFFF0_0000_0000_0000;

	typedef struct packed {
		logic [63:0] a_bits;
		logic [63:0] b_bits;
	} dpa_in_t;

	typedef struct packed {
		logic [63:0] sum_bits;
		logic        overflow;
	} dpa_out_t;

endpackage

/* hw/rtl/dpa_in_if.sv */
// Valid/ready channel that carries one operand pair item.
interface dpa_in_if import dpa_pkg::*; ();
	logic    valid;
	logic    ready;
	dpa_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dpa_out_if.sv */
// Valid/ready channel that carries one sum item.
interface dpa_out_if import dpa_pkg::*; ();
	logic     valid;
	logic     ready;
	dpa_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/double_precision_adder.sv */
// Six stage pipelined adder of two double precision bit patterns.
//
//   channel    direction  payload
//   operands   in         a_bits, b_bits
//   result     out        sum_bits, overflow
//
// One item may enter in every cycle in which the output is empty or taken.
// The stages are decode, align and add, magnitude, leading zero count,
// normalize, and round and pack; the last stage is the output register.
// The whole pipeline advances together when the output is empty or taken,
// so a stall holds every stage in place.
// Reset clears the valid bits of all stages.
module double_precision_adder import dpa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	dpa_in_if.sink        operands,
	dpa_out_if.source     result
);

	logic        en;
	logic [63:0] a, b;
	logic [10:0] ea, eb;
	logic        a_zero, b_zero;
	logic [11:0] ea_ext, eb_ext;
	logic [63:0] ma, mb;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic        byp_s1, byp_s2, byp_s3, byp_s4, byp_s5;
	logic [63:0] bv_s1, bv_s2, bv_s3, bv_s4, bv_s5;
	logic [63:0] big_s1, small_s1;
	logic [5:0]  sh_s1;
	logic [10:0] e_s1, e_s2, e_s3, e_s4;
	logic [63:0] acc_s2;
	logic        sign_s3, sign_s4, sign_s5;
	logic        zero_s3, zero_s4, zero_s5;
	logic [62:0] mag_s3, mag_s4;
	logic [5:0]  lz_s4;
	logic [61:0] n_s5;
	logic signed [12:0] e_s5;
	logic [63:0] sum_s6;
	logic        ovf_s6;

	logic [63:0] aligned;
	logic [63:0] neg_acc;
	logic [5:0]  lz;
	logic        found;
	logic [5:0]  lsh;
	logic [62:0] rnd;
	logic [61:0] rn;
	logic signed [12:0] ef;
	logic [52:0] m;
	logic [31:0] hi;
	logic [63:0] packed_sum;
	int          i;

	assign en = !v_s6 || result.ready;
	assign operands.ready = en;
	assign result.valid = v_s6;
	assign result.data.sum_bits = sum_s6;
	assign result.data.overflow = ovf_s6;

	assign a = operands.data.a_bits;
	assign b = operands.data.b_bits;
	assign ea = a[62:52];
	assign eb = b[62:52];
	assign a_zero = (a[62:0] == 63'd0);
	assign b_zero = (b[62:0] == 63'd0);
	assign ea_ext = {1'b0, ea};
	assign eb_ext = {1'b0, eb};

	always_comb begin
		ma = {11'd0, 1'b1, a[51:0]};
		mb = {11'd0, 1'b1, b[51:0]};
		if (a[63]) begin
			ma = 64'd0 - ma;
		end
		if (b[63]) begin
			mb = 64'd0 - mb;
		end
		ma = ma << 9;
		mb = mb << 9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= operands.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s1 <= 1'b1;
			bv_s1 <= a;
			big_s1 <= mb;
			small_s1 <= ma;
			sh_s1 <= 6'(eb - ea);
			e_s1 <= eb;
			if (a_zero) begin
				bv_s1 <= b;
			end else if (b_zero) begin
				bv_s1 <= a;
			end else if (ea_ext > eb_ext + 12'(MaxGap)) begin
				bv_s1 <= a;
			end else if (eb_ext > ea_ext + 12'(MaxGap)) begin
				bv_s1 <= b;
			end else begin
				byp_s1 <= 1'b0;
				if (eb < ea) begin
					big_s1 <= ma;
					small_s1 <= mb;
					sh_s1 <= 6'(ea - eb);
					e_s1 <= ea;
				end
			end
		end
	end

	assign aligned = 64'($signed(small_s1) >>> sh_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s2 <= byp_s1;
			bv_s2 <= bv_s1;
			e_s2 <= e_s1;
			acc_s2 <= big_s1 + aligned;
		end
	end

	assign neg_acc = 64'd0 - acc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s3 <= byp_s2;
			bv_s3 <= bv_s2;
			e_s3 <= e_s2;
			sign_s3 <= acc_s2[63];
			zero_s3 <= (acc_s2 == 64'd0);
			mag_s3 <= acc_s2[63] ? neg_acc[62:0] : acc_s2[62:0];
		end
	end

	always_comb begin
		lz = 6'd0;
		found = 1'b0;
		for (i = 62; i >= 0; i--) begin
			if (!found && mag_s3[i]) begin
				found = 1'b1;
				lz = 6'(62 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s4 <= byp_s3;
			bv_s4 <= bv_s3;
			e_s4 <= e_s3;
			sign_s4 <= sign_s3;
			zero_s4 <= zero_s3;
			mag_s4 <= mag_s3;
			lz_s4 <= lz;
		end
	end

	assign lsh = lz_s4 - 6'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s5 <= byp_s4;
			bv_s5 <= bv_s4;
			sign_s5 <= sign_s4;
			zero_s5 <= zero_s4;
			if (lz_s4 == 6'd0) begin
				n_s5 <= mag_s4[62:1];
				e_s5 <= $signed({2'b00, e_s4}) + 13'sd1;
			end else begin
				n_s5 <= 62'(mag_s4 << lsh);
				e_s5 <= $signed({2'b00, e_s4}) - $signed({7'd0, lsh});
			end
		end
	end

	always_comb begin
		rnd = {1'b0, n_s5} + (n_s5[9] ? 63'd256 : 63'd255);
		ef = e_s5;
		rn = rnd[61:0];
		if (rnd[62]) begin
			rn = rnd[62:1];
			ef = e_s5 + 13'sd1;
		end
		m = rn[61:9];
		hi = {sign_s5 | ef[11], ef[10:0], m[51:32]};
		packed_sum = {hi, m[31:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s6 <= 1'b0;
			if (byp_s5) begin
				sum_s6 <= bv_s5;
			end else if (zero_s5) begin
				sum_s6 <= 64'd0;
			end else if (ef >= $signed({2'b00, ExpMax})) begin
				sum_s6 <= sign_s5 ? NegInf : PosInf;
				ovf_s6 <= 1'b1;
			end else begin
				sum_s6 <= packed_sum;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.overflow |-> result.data.sum_bits[62:0] == PosInf[62:0])
		else $error("overflow result is not an infinity");

	assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready && operands.data.a_bits[62:0] == 63'd0
		|=> byp_s1 && bv_s1 == $past(operands.data.b_bits))
		else $error("zero first operand did not pass the second operand through");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !byp_s5 && !zero_s5 |-> n_s5[61])
		else $error("normalized mantissa lacks its leading one");

endmodule

/* tb/sv/dpa_sum_checker.sv */
// Checker that predicts every sum of the double precision adder and compares it with the block.
module dpa_sum_checker import dpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dpa_in_if           operands,
	dpa_out_if          result,
	output int unsigned errors,
	output int unsigned pending
);

	dpa_out_t sums_due[$];

	function automatic logic [63:0] shift_arith(input logic [63:0] x, input int unsigned n);
		int unsigned k;
		k = (n > 63) ? 63 : n;
		return $signed(x) >>> k;
	endfunction

	function automatic dpa_out_t predict_sum(input logic [63:0] a, input logic [63:0] b);
		dpa_out_t r;
		int ea;
		int eb;
		int e;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] acc;
		logic sgn;
		logic [31:0] hi;
		r.overflow = 1'b0;
		r.sum_bits = '0;
		sgn = 1'b0;
		if (a[62:0] == '0) begin
			r.sum_bits = b;
			return r;
		end
		if (b[62:0] == '0) begin
			r.sum_bits = a;
			return r;
		end
		ea = int'(a[62:52]);
		eb = int'(b[62:52]);
		if (eb + int'(MaxGap) < ea) begin
			r.sum_bits = a;
			return r;
		end
		if (ea + int'(MaxGap) < eb) begin
			r.sum_bits = b;
			return r;
		end
		ma = {12'h001, a[51:0]};
		mb = {12'h001, b[51:0]};
		if (a[63]) ma = -ma;
		if (b[63]) mb = -mb;
		ma = ma << 9;
		mb = mb << 9;
		if (eb >= ea) begin
			ma = shift_arith(ma, eb - ea);
			e = eb;
		end else begin
			mb = shift_arith(mb, ea - eb);
			e = ea;
		end
		acc = ma + mb;
		if (acc[63]) begin
			sgn = 1'b1;
			acc = -acc;
		end else if (acc == '0) begin
			return r;
		end
		while (acc[63:61] == 3'b000) begin
			acc = acc << 1;
			e--;
		end
		if (acc[62]) begin
			e++;
			acc = acc >> 1;
		end
		acc = acc + (acc[9] ? 64'd256 : 64'd255);
		if (acc[62]) begin
			e++;
			acc = acc >> 1;
		end
		acc = acc >> 9;
		if (e < 2047) begin
			hi = {sgn, 31'b0} | (32'(e) << 20) | (acc[63:32] & 32'hFFEF_FFFF);
			r.sum_bits = {hi, acc[31:0]};
		end else begin
			r.sum_bits = sgn ? NegInf : PosInf;
			r.overflow = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dpa_out_t want;
		int unsigned bad;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (operands.valid && operands.ready)
				sums_due.push_back(predict_sum(operands.data.a_bits, operands.data.b_bits));
			if (result.valid && result.ready) begin
				if (sums_due.size() == 0) begin
					$display("%0t: unexpected sum %h", $realtime, result.data.sum_bits);
					bad++;
				end else begin
					want = sums_due.pop_front();
					if (want.sum_bits !== result.data.sum_bits) begin
						$display("%0t: sum_bits expected %h actual %h", $realtime,
							want.sum_bits, result.data.sum_bits);
						bad++;
					end
					if (want.overflow !== result.data.overflow) begin
						$display("%0t: overflow expected %b actual %b", $realtime,
							want.overflow, result.data.overflow);
						bad++;
					end
				end
			end
			errors <= errors + bad;
			pending <= sums_due.size();
		end
	end

endmodule

/* tb/sv/double_precision_adder_test.sv */
// Top of the testbench: drives operand pairs and result stalls and gives the verdict.
module double_precision_adder_test;
	import dpa_pkg::*;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned cycles;
	bit          calm;
	bit          hold_off;
	bit          stim_done;
	logic [63:0] pairs_a[$];
	logic [63:0] pairs_b[$];

	dpa_in_if  operands ();
	dpa_out_if result ();

	double_precision_adder u_top (.clk(clk), .arst_n(arst_n), .operands(operands),
		.result(result));
	dpa_sum_checker u_check (.clk(clk), .arst_n(arst_n), .operands(operands),
		.result(result), .errors(errors), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rand_double(input int unsigned mode, input int ebase);
		logic [63:0] x;
		int ex;
		x = {$urandom, $urandom};
		case (mode)
			0: ex = ebase + $urandom_range(0, 8) - 4;
			1: ex = ebase + $urandom_range(0, 120) - 60;
			2: ex = $urandom_range(2030, 2047);
			3: ex = $urandom_range(0, 20);
			default: ex = $urandom_range(0, 2047);
		endcase
		if (ex < 0) ex = 0;
		if (ex > 2047) ex = 2047;
		x[62:52] = ex[10:0];
		return x;
	endfunction

	task automatic add_pair(input logic [63:0] a, input logic [63:0] b);
		pairs_a.push_back(a);
		pairs_b.push_back(b);
	endtask

	initial begin
		logic [63:0] a;
		logic [63:0] b;
		int eb;
		int unsigned m;
		add_pair(64'h0, 64'h3FF0_0000_0000_0000);
		add_pair(64'h8000_0000_0000_0000, 64'hC000_0000_0000_0001);
		add_pair(64'h4008_0000_0000_0000, 64'h0);
		add_pair(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
		add_pair(64'h0, 64'h8000_0000_0000_0000);
		add_pair(64'h4370_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		add_pair(64'h3FF0_0000_0000_0000, 64'h4370_0000_0000_0000);
		add_pair(64'h4360_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		add_pair(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
		add_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
		add_pair(64'hFFEF_FFFF_FFFF_FFFF, 64'hFFE0_0000_0000_0000);
		add_pair(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
		add_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_pair(64'h0010_0000_0000_0000, 64'h8010_0000_0000_0001);
		add_pair(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0003);
		add_pair(64'h3FF0_0000_0000_0001, 64'h3CA0_0000_0000_0000);
		add_pair(64'h3FF0_0000_0000_0003, 64'h3CA0_0000_0000_0000);
		add_pair(64'h3FF0_0000_0000_0000, 64'hBFEF_FFFF_FFFF_FFFF);
		add_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		add_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		repeat (1150) begin
			m = $urandom_range(0, 9);
			eb = $urandom_range(0, 2047);
			a = rand_double(m < 5 ? 0 : m - 4, eb);
			b = rand_double(m < 5 ? 0 : m - 4, eb);
			if ($urandom_range(0, 9) == 0) b = {~a[63], a[62:0]};
			if ($urandom_range(0, 29) == 0) a[62:0] = '0;
			add_pair(a, b);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		bit held;
		held = 1'b0;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				result.ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			result.ready <= calm || ($urandom_range(0, 99) >= 27);
		end
	end

	initial begin
		int unsigned n;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.data = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		n = 0;
		while (pairs_a.size() > 0) begin
			@(posedge clk);
			if (operands.valid && !operands.ready) continue;
			if (n == 300) hold_off <= 1'b1;
			calm <= (n >= 500 && n < 700);
			if (n == 800) begin
				operands.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (!calm && $urandom_range(0, 99) < 27) begin
				operands.valid <= 1'b0;
			end else begin
				operands.valid <= 1'b1;
				operands.data.a_bits <= pairs_a.pop_front();
				operands.data.b_bits <= pairs_b.pop_front();
				n++;
			end
		end
		@(posedge clk);
		while (!operands.ready) @(posedge clk);
		operands.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/dpa_pkg.sv
hw/rtl/dpa_in_if.sv
hw/rtl/dpa_out_if.sv
hw/rtl/double_precision_adder.sv
tb/sv/dpa_sum_checker.sv
tb/sv/double_precision_adder_test.sv
